>>> design/assert_macros.svh
// Assertion macros used by the port level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen outside reset.
`define CHK_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> design/tncs_pkg.sv
// Types and constants of the triangle normal and centroid setup pipeline.
`timescale 1ns / 1ps
package tncs_pkg;

	localparam int CW  = 65;   // cross product magnitude
	localparam int QW  = 130;  // square of a cross component
	localparam int SW  = 132;  // sum of squares
	localparam int RW  = 196;  // remainder and trial term
	localparam int PW  = 164;  // running n*S
	localparam int NW  = 31;   // normal magnitude bits
	localparam int NORM_STEPS = NW;
	localparam int LATENCY = 3 + 3 + NORM_STEPS + 1;

	// (2^35 + 1) / 3, exact floor(x/3) for x below 2^35
	localparam logic [33:0] DIV3_MAGIC = 34'h2AAAAAAAB;
	localparam int DIV3_SHIFT = 35;

	typedef struct packed {
		logic [2:0][2:0][31:0] v;   // [vertex][axis]
		logic [15:0]           mat;
	} tri_t;

	typedef struct packed {
		logic [2:0][CW-1:0] cm;
		logic [2:0]         cn;
		logic [2:0][31:0]   cent;
		logic [15:0]        mat;
	} front_t;

	typedef struct packed {
		logic               degen;
		logic [SW-1:0]      s;
		logic [2:0][RW-1:0] r;
		logic [2:0][PW-1:0] p;
		logic [2:0][NW-1:0] n;
		logic [2:0]         cn;
		logic [2:0][31:0]   cent;
		logic [15:0]        mat;
	} norm_t;

endpackage

>>> design/tncs_front.sv
// Edges, centroid division and signed cross product, three stages.
`timescale 1ns / 1ps
module tncs_front import tncs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  tri_t   in_tri,
	output logic   out_valid,
	output front_t out_data
);

	logic [2:0][32:0] e1_s1, e2_s1;
	logic [2:0][33:0] sum_s1;
	logic [15:0]      mat_s1, mat_s2;
	logic             v_s1, v_s2, v_s3;

	logic [2:0][63:0] pm_s2, qm_s2;
	logic [2:0]       pn_s2, qn_s2;
	logic [2:0][66:0] cprod_s2;
	logic [2:0]       csgn_s2;

	front_t           d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: edges and coordinate sums
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			e1_s1[a] <= {in_tri.v[1][a][31], in_tri.v[1][a]}
				- {in_tri.v[0][a][31], in_tri.v[0][a]};
			e2_s1[a] <= {in_tri.v[2][a][31], in_tri.v[2][a]}
				- {in_tri.v[0][a][31], in_tri.v[0][a]};
			sum_s1[a] <= {{2{in_tri.v[0][a][31]}}, in_tri.v[0][a]}
				+ {{2{in_tri.v[1][a][31]}}, in_tri.v[1][a]}
				+ {{2{in_tri.v[2][a][31]}}, in_tri.v[2][a]};
		end
		mat_s1 <= in_tri.mat;
	end

	// stage 2: magnitude products of the cross terms, centroid times 1/3
	logic [2:0][31:0] m1, m2;
	logic [2:0][33:0] smag;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			m1[a]   = e1_s1[a][32] ? 32'(-e1_s1[a]) : e1_s1[a][31:0];
			m2[a]   = e2_s1[a][32] ? 32'(-e2_s1[a]) : e2_s1[a][31:0];
			smag[a] = sum_s1[a][33] ? -sum_s1[a] : sum_s1[a];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			// c_i = e1[j]*e2[k] - e1[k]*e2[j], j = i+1, k = i+2 (mod 3)
			int j, k;
			j = (i == 2) ? 0 : i + 1;
			k = (i == 0) ? 2 : i - 1;
			pm_s2[i] <= 64'(m1[j]) * 64'(m2[k]);
			qm_s2[i] <= 64'(m1[k]) * 64'(m2[j]);
			pn_s2[i] <= e1_s1[j][32] ^ e2_s1[k][32];
			qn_s2[i] <= e1_s1[k][32] ^ e2_s1[j][32];
			cprod_s2[i] <= 67'(smag[i][32:0]) * 67'(DIV3_MAGIC);
			csgn_s2[i]  <= sum_s1[i][33];
		end
		mat_s2 <= mat_s1;
	end

	// stage 3: signed difference to magnitude and sign, centroid sign
	logic [2:0][65:0] sp, sq, cd;
	logic [2:0][31:0] q3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sp[i] = pn_s2[i] ? -{2'b00, pm_s2[i]} : {2'b00, pm_s2[i]};
			sq[i] = qn_s2[i] ? -{2'b00, qm_s2[i]} : {2'b00, qm_s2[i]};
			cd[i] = sp[i] - sq[i];
			q3[i] = cprod_s2[i][DIV3_SHIFT +: 32];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s3.cn[i]   <= cd[i][65];
			d_s3.cm[i]   <= cd[i][65] ? CW'(-cd[i]) : cd[i][CW-1:0];
			d_s3.cent[i] <= csgn_s2[i] ? -q3[i] : q3[i];
		end
		d_s3.mat <= mat_s2;
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

>>> design/tncs_square.sv
// Squares of the cross components from split products, sum and start remainder.
`timescale 1ns / 1ps
module tncs_square import tncs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  front_t in_data,
	output logic   out_valid,
	output norm_t  out_data
);

	localparam int LW = 33;

	logic             v_s4, v_s5, v_s6;
	logic [2:0][63:0] hh_s4;
	logic [2:0][64:0] hl_s4;
	logic [2:0][65:0] ll_s4;
	front_t           f_s4, f_s5;
	logic [2:0][QW-1:0] sq_s5;
	norm_t            d_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 4: partial products, m = h*2^33 + l
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hh_s4[i] <= 64'(in_data.cm[i][CW-1:LW]) * 64'(in_data.cm[i][CW-1:LW]);
			hl_s4[i] <= 65'(in_data.cm[i][CW-1:LW]) * 65'(in_data.cm[i][LW-1:0]);
			ll_s4[i] <= 66'(in_data.cm[i][LW-1:0]) * 66'(in_data.cm[i][LW-1:0]);
		end
		f_s4 <= in_data;
	end

	// stage 5: m^2 = h^2*2^66 + h*l*2^34 + l^2
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= {hh_s4[i], 66'd0} + (QW'(hl_s4[i]) << (LW + 1)) + QW'(ll_s4[i]);
		end
		f_s5 <= f_s4;
	end

	// stage 6: S and the starting remainder m^2 * 2^60
	logic [SW-1:0] s_sum;
	assign s_sum = SW'(sq_s5[0]) + SW'(sq_s5[1]) + SW'(sq_s5[2]);

	always_ff @(posedge clk) begin
		d_s6.s     <= s_sum;
		d_s6.degen <= (s_sum == '0);
		for (int i = 0; i < 3; i++) begin
			d_s6.r[i] <= RW'(sq_s5[i]) << 60;
			d_s6.p[i] <= '0;
			d_s6.n[i] <= '0;
		end
		d_s6.cn   <= f_s5.cn;
		d_s6.cent <= f_s5.cent;
		d_s6.mat  <= f_s5.mat;
	end

	assign out_valid = v_s6;
	assign out_data  = d_s6;

endmodule

>>> design/tncs_norm_step.sv
// One bit of the exact normalization n = floor(m*2^30/sqrt(S)) for all three lanes.
`timescale 1ns / 1ps
module tncs_norm_step import tncs_pkg::*; #(
	parameter int BIT = 30
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  norm_t in_data,
	output logic  out_valid,
	output norm_t out_data
);

	// trial: (n + 2^b)^2 S - n^2 S = (n*S << (b+1)) + (S << 2b)
	logic [2:0][RW-1:0] d;
	logic [2:0]         take;
	norm_t              nx;

	always_comb begin
		nx = in_data;
		for (int i = 0; i < 3; i++) begin
			d[i]    = (RW'(in_data.p[i]) << (BIT + 1)) + (RW'(in_data.s) << (2 * BIT));
			take[i] = (in_data.r[i] >= d[i]);
			if (take[i]) begin
				nx.r[i] = in_data.r[i] - d[i];
				nx.p[i] = in_data.p[i] + (PW'(in_data.s) << BIT);
				nx.n[i] = in_data.n[i] | (NW'(1) << BIT);
			end
		end
	end

	logic  v_q;
	norm_t d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nx;
	end

	assign out_valid = v_q;
	assign out_data  = d_q;

endmodule

>>> design/triangle_normal_centroid_setup_unit.sv
// Top level of the triangle unit normal and centroid setup pipeline.
// One triangle is taken on every cycle that start is high (busy stays low), and
// its result appears on the output ports with done high once it has passed all
// stages, one result per cycle with no backpressure. Three stages form the edges,
// the centroid and the cross product, three more square it via split 32/33-bit
// products, 31 stages each resolve one bit of the exact normal magnitude with a
// wide add and compare in all three lanes, and one stage applies the sign.
`timescale 1ns / 1ps
module triangle_normal_centroid_setup_unit import tncs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] v0_x,
	input  logic signed [31:0] v0_y,
	input  logic signed [31:0] v0_z,
	input  logic signed [31:0] v1_x,
	input  logic signed [31:0] v1_y,
	input  logic signed [31:0] v1_z,
	input  logic signed [31:0] v2_x,
	input  logic signed [31:0] v2_y,
	input  logic signed [31:0] v2_z,
	input  logic        [15:0] material_in,
	output logic               done,
	output logic signed [31:0] centroid_x,
	output logic signed [31:0] centroid_y,
	output logic signed [31:0] centroid_z,
	output logic signed [31:0] normal_x,
	output logic signed [31:0] normal_y,
	output logic signed [31:0] normal_z,
	output logic        [15:0] material_out,
	output logic               degenerate
);

	tri_t   tri_in;
	logic   f_valid, q_valid;
	front_t f_data;
	norm_t  q_data;

	assign busy = 1'b0;

	always_comb begin
		tri_in.v[0][0] = v0_x;
		tri_in.v[0][1] = v0_y;
		tri_in.v[0][2] = v0_z;
		tri_in.v[1][0] = v1_x;
		tri_in.v[1][1] = v1_y;
		tri_in.v[1][2] = v1_z;
		tri_in.v[2][0] = v2_x;
		tri_in.v[2][1] = v2_y;
		tri_in.v[2][2] = v2_z;
		tri_in.mat     = material_in;
	end

	tncs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_tri    (tri_in),
		.out_valid (f_valid),
		.out_data  (f_data)
	);

	tncs_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_data   (f_data),
		.out_valid (q_valid),
		.out_data  (q_data)
	);

	logic  [NORM_STEPS:0] nv;
	norm_t                nd [NORM_STEPS+1];

	assign nv[0] = q_valid;
	assign nd[0] = q_data;

	for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
		tncs_norm_step #(.BIT(NW - 1 - g)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (nv[g]),
			.in_data   (nd[g]),
			.out_valid (nv[g+1]),
			.out_data  (nd[g+1])
		);
	end

	// output stage: sign, zero normal for a degenerate triangle
	norm_t            last;
	logic [2:0][31:0] nrm;
	logic             done_q;
	logic [2:0][31:0] cent_q, nrm_q;
	logic [15:0]      mat_q;
	logic             degen_q;

	assign last = nd[NORM_STEPS];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (last.degen) begin
				nrm[i] = '0;
			end else if (last.cn[i]) begin
				nrm[i] = -{1'b0, last.n[i]};
			end else begin
				nrm[i] = {1'b0, last.n[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= nv[NORM_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		cent_q  <= last.cent;
		nrm_q   <= nrm;
		mat_q   <= last.mat;
		degen_q <= last.degen;
	end

	assign done         = done_q;
	assign centroid_x   = cent_q[0];
	assign centroid_y   = cent_q[1];
	assign centroid_z   = cent_q[2];
	assign normal_x     = nrm_q[0];
	assign normal_y     = nrm_q[1];
	assign normal_z     = nrm_q[2];
	assign material_out = mat_q;
	assign degenerate   = degen_q;

endmodule

>>> design/tncs_checker.sv
// Port level checks of the setup unit and their bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tncs_checker import tncs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] normal_x,
	input logic signed [31:0] normal_y,
	input logic signed [31:0] normal_z,
	input logic               degenerate
);

	`CHK_ASSERT(a_latency, clk, arst_n, (start && !busy) |-> ##LATENCY done, "result beat missing")
	`CHK_ASSERT(a_no_spurious, clk, arst_n, done |-> $past(start && !busy, LATENCY), "unexpected result beat")
	`CHK_ASSERT(a_degen_zero, clk, arst_n, (done && degenerate) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0), "degenerate normal not zero")
	`CHK_NEVER(a_range, clk, arst_n, done && (normal_x > 32'sd1073741824 || normal_x < -32'sd1073741824), "normal x out of range")

endmodule

bind triangle_normal_centroid_setup_unit tncs_checker u_tncs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.normal_x   (normal_x),
	.normal_y   (normal_y),
	.normal_z   (normal_z),
	.degenerate (degenerate)
);
